// File: rtl/core/cfp_pkg.sv
package cfp_pkg;

    // parse phases, one-hot
    typedef enum logic [8:0] {
        PH_HEAD1 = 9'b000000001,
        PH_HEAD2 = 9'b000000010,
        PH_ID    = 9'b000000100,
        PH_LEN   = 9'b000001000,
        PH_DATA  = 9'b000010000,
        PH_CRC1  = 9'b000100000,
        PH_CRC2  = 9'b001000000,
        PH_TAIL1 = 9'b010000000,
        PH_TAIL2 = 9'b100000000
    } phase_t;

    // event codes reported with each result
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_GOOD    = 3'd2,
        EV_CRC     = 3'd3,
        EV_TAIL    = 3'd4
    } event_t;

    // configuration register indexes
    localparam logic [7:0] REG_HEADER_FIRST  = 8'd0;
    localparam logic [7:0] REG_HEADER_SECOND = 8'd1;
    localparam logic [7:0] REG_TAIL_FIRST    = 8'd2;
    localparam logic [7:0] REG_TAIL_SECOND   = 8'd3;

    // configuration reset values
    localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
    localparam logic [7:0] TAIL_FIRST_RST    = 8'h0D;
    localparam logic [7:0] TAIL_SECOND_RST   = 8'h0A;

    // crc-16/modbus constants
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] tail_first;
        logic [7:0] tail_second;
    } cfg_t;

    typedef struct packed {
        event_t     kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_id;
        logic [7:0] frame_length;
    } result_t;

    // one byte of reflected crc-16 update
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/crc16_frame_parser.sv
// Byte-serial frame parser: header_first, header_second, id, length L, L payload
// bytes, CRC-16/MODBUS of the payload (low byte first), tail_first, tail_second.
// Every received byte gives exactly one result: nothing, a payload byte with its
// index, frame good, crc error or tail error; any error resumes header hunting.
// Throughput is one byte per cycle unless out_ready low stalls the result register;
// each byte passes through the input register and the result register around
// the combinational parser step (state update plus one eight-bit CRC update).
// Config registers (index 0..3: header_first, header_second, tail_first,
// tail_second) are always ready and should be written only while idle.
module crc16_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    output logic [7:0]  frame_id,
    output logic [7:0]  frame_length
);

    cfp_pkg::cfg_t    cfg;
    cfp_pkg::result_t step_result;
    cfp_pkg::result_t result_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;

    assign cfg_ready = 1'b1;

    cfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pipeline moves when the result register is free or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    cfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance && in_valid_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = result_reg.kind;
    assign payload_byte  = result_reg.payload_byte;
    assign payload_index = result_reg.payload_index;
    assign frame_id      = result_reg.frame_id;
    assign frame_length  = result_reg.frame_length;

endmodule

// File: rtl/core/cfp_cfg_regs.sv
module cfp_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic [7:0]      cfg_index,
    input  logic [7:0]      cfg_data,
    output cfp_pkg::cfg_t   cfg
);

    cfp_pkg::cfg_t cfg_reg;

    // register writes on a config transfer, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= cfp_pkg::HEADER_FIRST_RST;
            cfg_reg.header_second <= cfp_pkg::HEADER_SECOND_RST;
            cfg_reg.tail_first    <= cfp_pkg::TAIL_FIRST_RST;
            cfg_reg.tail_second   <= cfp_pkg::TAIL_SECOND_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cfp_pkg::REG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data;
                cfp_pkg::REG_HEADER_SECOND: cfg_reg.header_second <= cfg_data;
                cfp_pkg::REG_TAIL_FIRST:    cfg_reg.tail_first    <= cfg_data;
                cfp_pkg::REG_TAIL_SECOND:   cfg_reg.tail_second   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/cfp_parser.sv
module cfp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    input  cfp_pkg::cfg_t      cfg,
    output cfp_pkg::result_t   result
);

    cfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      id_reg, id_next;
    logic [7:0]      len_reg, len_next;
    logic [7:0]      count_reg, count_next;
    logic [15:0]     crc_reg, crc_next;

    logic [15:0]     crc_step;
    logic [7:0]      count_inc;
    cfp_pkg::event_t kind;
    logic [7:0]      pbyte;
    logic [7:0]      pidx;

    assign crc_step  = cfp_pkg::crc_update(crc_reg, rx_byte);
    assign count_inc = count_reg + 8'd1;

    // per-byte frame state step
    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        kind       = cfp_pkg::EV_NONE;
        pbyte      = 8'd0;
        pidx       = 8'd0;
        case (phase_reg)
            cfp_pkg::PH_HEAD1:
            begin
                if (rx_byte == cfg.header_first)
                begin
                    phase_next = cfp_pkg::PH_HEAD2;
                end
            end
            cfp_pkg::PH_HEAD2:
            begin
                if (rx_byte == cfg.header_second)
                begin
                    phase_next = cfp_pkg::PH_ID;
                end
                else
                begin
                    phase_next = cfp_pkg::PH_HEAD1;
                    id_next    = 8'd0;
                    len_next   = 8'd0;
                    count_next = 8'd0;
                    crc_next   = cfp_pkg::CRC_INIT;
                end
            end
            cfp_pkg::PH_ID:
            begin
                id_next    = rx_byte;
                count_next = 8'd0;
                crc_next   = cfp_pkg::CRC_INIT;
                phase_next = cfp_pkg::PH_LEN;
            end
            cfp_pkg::PH_LEN:
            begin
                len_next   = rx_byte;
                // empty payload goes straight to the crc bytes
                phase_next = (rx_byte == 8'd0) ? cfp_pkg::PH_CRC1 : cfp_pkg::PH_DATA;
            end
            cfp_pkg::PH_DATA:
            begin
                kind       = cfp_pkg::EV_PAYLOAD;
                pbyte      = rx_byte;
                pidx       = count_reg;
                crc_next   = crc_step;
                count_next = count_inc;
                if (count_inc >= len_reg)
                begin
                    phase_next = cfp_pkg::PH_CRC1;
                end
            end
            cfp_pkg::PH_CRC1, cfp_pkg::PH_CRC2, cfp_pkg::PH_TAIL1:
            begin
                if ((phase_reg == cfp_pkg::PH_CRC1) && (rx_byte == crc_reg[7:0]))
                begin
                    phase_next = cfp_pkg::PH_CRC2;
                end
                else if ((phase_reg == cfp_pkg::PH_CRC2) && (rx_byte == crc_reg[15:8]))
                begin
                    phase_next = cfp_pkg::PH_TAIL1;
                end
                else if ((phase_reg == cfp_pkg::PH_TAIL1) && (rx_byte == cfg.tail_first))
                begin
                    phase_next = cfp_pkg::PH_TAIL2;
                end
                else
                begin
                    kind       = (phase_reg == cfp_pkg::PH_TAIL1) ?
                                 cfp_pkg::EV_TAIL : cfp_pkg::EV_CRC;
                    phase_next = cfp_pkg::PH_HEAD1;
                    id_next    = 8'd0;
                    len_next   = 8'd0;
                    count_next = 8'd0;
                    crc_next   = cfp_pkg::CRC_INIT;
                end
            end
            cfp_pkg::PH_TAIL2:
            begin
                kind       = (rx_byte == cfg.tail_second) ?
                             cfp_pkg::EV_GOOD : cfp_pkg::EV_TAIL;
                phase_next = cfp_pkg::PH_HEAD1;
                id_next    = 8'd0;
                len_next   = 8'd0;
                count_next = 8'd0;
                crc_next   = cfp_pkg::CRC_INIT;
            end
            default:
            begin
                phase_next = cfp_pkg::PH_HEAD1;
                id_next    = 8'd0;
                len_next   = 8'd0;
                count_next = 8'd0;
                crc_next   = cfp_pkg::CRC_INIT;
            end
        endcase
    end

    // frame fields reported as held before this byte, zero when nothing happens
    always_comb
    begin
        result.kind          = kind;
        result.payload_byte  = pbyte;
        result.payload_index = pidx;
        result.frame_id      = (kind == cfp_pkg::EV_NONE) ? 8'd0 : id_reg;
        result.frame_length  = (kind == cfp_pkg::EV_NONE) ? 8'd0 : len_reg;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cfp_pkg::PH_HEAD1;
            id_reg    <= 8'd0;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
            crc_reg   <= cfp_pkg::CRC_INIT;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

endmodule
